### rtl/scs_pkg.sv
// Shared constants and helpers for the source comment stripper.
package scs_pkg;

  // Default depth of the held-whitespace memory.
  localparam int SPACE_DEPTH_DEFAULT = 32;

  // Character codes the scanner looks for.
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_HASH  = 8'd35;
  localparam logic [7:0] CHAR_STAR  = 8'd42;
  localparam logic [7:0] CHAR_SLASH = 8'd47;

  // Comment style register codes.
  localparam logic [1:0] STYLE_C    = 2'd0;
  localparam logic [1:0] STYLE_CSS  = 2'd1;
  localparam logic [1:0] STYLE_HASH = 2'd2;
  localparam logic [1:0] STYLE_NONE = 2'd3;

  // Scan mode codes.
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  // Whitespace that is held back rather than emitted at once.
  function automatic logic is_space(logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR);
  endfunction

endpackage

### rtl/scs_space_ram.sv
// Held-whitespace memory: one write port, one registered read port.
module scs_space_ram
  import scs_pkg::*;
#(
  parameter int DEPTH = SPACE_DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered and updated only when re is high.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/source_comment_stripper.sv
// Top level of the streaming source comment stripper.
// Text enters one byte per word and leaves with comments removed according to
// comment_style (0 line and block comments, 1 block only, 2 hash to line end,
// 3 none). Trailing whitespace is trimmed, empty lines are dropped and every
// kept line ends in LF. Held whitespace lives in a SPACE_DEPTH-entry memory
// tracked by a fill count, so no clearing pass runs after reset. Each released
// held whitespace byte takes a memory read state and then an output load
// state, and the input is accepted only when the previous word's output is
// fully loaded into the output register. Output stalls hold the sequencer.
module source_comment_stripper
  import scs_pkg::*;
#(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration: comment_style.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  // Input stream. tdata: text_byte[7:0]. tlast: end_of_text.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  // Output stream. tdata: out_byte[7:0]. tlast: last_of_run.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  // tuser: is_byte[0], document_end[1], space_overflow[2].
  output logic [2:0] m_axis_tuser
);

  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(SPACE_DEPTH);

  // Working copy of the scanner state plus what one word produces.
  typedef struct packed {
    logic [1:0]      mode;
    logic            sl;
    logic            st;
    logic            lc;
    logic [CW-1:0]   cnt;
    logic            lost;
    logic            flush;
    logic [CW-1:0]   fcnt;
    logic            flost;
    logic [1:0]      n;
    logic [2:0][7:0] tb;
    logic            push;
    logic [7:0]      pbyte;
    logic [AW-1:0]   paddr;
  } step_t;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_LD, S_TAIL} seq_state_t;

  // Content byte: release held whitespace first, then the byte itself.
  function automatic step_t f_emit(step_t s, logic [7:0] x);
    step_t r;
    r = s;
    if (r.cnt != '0) begin
      r.flush = 1'b1;
      r.fcnt  = r.cnt;
      r.flost = r.lost;
    end
    r.cnt   = '0;
    r.lost  = 1'b0;
    r.tb[r.n] = x;
    r.n     = r.n + 2'd1;
    r.lc    = 1'b1;
    return r;
  endfunction

  // Whitespace goes to the memory, anything else is content.
  function automatic step_t f_keep(step_t s, logic [7:0] x);
    step_t r;
    r = s;
    if (is_space(x)) begin
      if (r.cnt < CNT_FULL) begin
        r.push  = 1'b1;
        r.pbyte = x;
        r.paddr = r.cnt[AW-1:0];
        r.cnt   = r.cnt + CW'(1);
      end else begin
        r.lost = 1'b1;
      end
    end else begin
      r = f_emit(r, x);
    end
    return r;
  endfunction

  // Byte in ordinary text.
  function automatic step_t f_plain(step_t s, logic [7:0] x, logic [1:0] style);
    step_t r;
    r = s;
    if (style == STYLE_HASH && x == CHAR_HASH) begin
      r.mode = MODE_LINE;
    end else if (style <= STYLE_CSS && x == CHAR_SLASH) begin
      r.sl = 1'b1;
    end else begin
      r = f_keep(r, x);
    end
    return r;
  endfunction

  // Line end: a held slash is content, a line with content gets its LF.
  function automatic step_t f_endline(step_t s);
    step_t r;
    r = s;
    if (r.sl) begin
      r.sl = 1'b0;
      r = f_emit(r, CHAR_SLASH);
    end
    if (r.lc) begin
      r.tb[r.n] = CHAR_LF;
      r.n = r.n + 2'd1;
    end
    r.lc   = 1'b0;
    r.cnt  = '0;
    r.lost = 1'b0;
    r.st   = 1'b0;
    if (r.mode == MODE_LINE) begin
      r.mode = MODE_TEXT;
    end
    return r;
  endfunction

  // Configuration and scanner state.
  logic [1:0]    comment_style;
  logic [1:0]    scan_mode;
  logic          slash_held;
  logic          star_seen;
  logic          line_content;
  logic [CW-1:0] ws_count;
  logic          ws_lost;

  // Sequencer and output register.
  seq_state_t      state;
  logic [CW-1:0]   fl_cnt;
  logic [CW-1:0]   fl_idx;
  logic            fl_lost;
  logic [2:0][7:0] tail_byte;
  logic [1:0]      tail_n;
  logic [1:0]      tail_idx;
  logic            tail_bare;
  logic            tail_eot;
  logic            pend;
  logic [7:0]      pend_byte;
  logic [AW-1:0]   pend_addr;
  logic            o_valid;
  logic [7:0]      o_byte;
  logic            o_last;
  logic [2:0]      o_user;

  logic          in_hs;
  logic          out_free;
  logic          o_load;
  logic          tail_last;
  step_t         s;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !o_valid || m_axis_tready;
  assign o_load        = ((state == S_LD) || (state == S_TAIL)) && out_free;
  assign tail_last     = (tail_idx == tail_n - 2'd1);

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_byte;
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_user;

  // Scan one input word against the current state.
  always_comb begin
    s = '0;
    s.mode = scan_mode;
    s.sl   = slash_held;
    s.st   = star_seen;
    s.lc   = line_content;
    s.cnt  = ws_count;
    s.lost = ws_lost;
    if (s_axis_tdata == CHAR_LF) begin
      s = f_endline(s);
    end else if (s.sl) begin
      s.sl = 1'b0;
      if (s_axis_tdata == CHAR_SLASH && comment_style == STYLE_C) begin
        s.mode = MODE_LINE;
      end else if (s_axis_tdata == CHAR_STAR && comment_style <= STYLE_CSS) begin
        s.mode = MODE_BLOCK;
        s.st   = 1'b0;
      end else begin
        s = f_emit(s, CHAR_SLASH);
        s = f_plain(s, s_axis_tdata, comment_style);
      end
    end else if (s.mode == MODE_LINE) begin
      s.mode = MODE_LINE;
    end else if (s.mode == MODE_BLOCK) begin
      if (s.st && s_axis_tdata == CHAR_SLASH) begin
        s.mode = MODE_TEXT;
        s.st   = 1'b0;
      end else begin
        s.st = (s_axis_tdata == CHAR_STAR);
      end
    end else begin
      s = f_plain(s, s_axis_tdata, comment_style);
    end
    if (s_axis_tlast) begin
      if (s_axis_tdata != CHAR_LF) begin
        s = f_endline(s);
      end
      s.mode = MODE_TEXT;
      s.sl   = 1'b0;
      s.st   = 1'b0;
      s.lc   = 1'b0;
      s.cnt  = '0;
      s.lost = 1'b0;
    end
  end

  // Memory port selection: a push waits until a release in the same word is read out.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s.paddr;
    ram_wdata = s.pbyte;
    if (in_hs && s.push && !s.flush) begin
      ram_we = 1'b1;
    end else if (state == S_TAIL && out_free && tail_last && pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = pend_byte;
    end
    ram_re = (state == S_RD);
  end

  scs_space_ram #(
    .DEPTH(SPACE_DEPTH)
  ) u_space_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(fl_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Scanner state, sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      comment_style <= STYLE_C;
      scan_mode     <= MODE_TEXT;
      slash_held    <= 1'b0;
      star_seen     <= 1'b0;
      line_content  <= 1'b0;
      ws_count      <= '0;
      ws_lost       <= 1'b0;
      state         <= S_IDLE;
      pend          <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        comment_style <= cfg_data;
      end
      // The output register takes a new word or empties once its word is taken.
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (o_valid && m_axis_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_hs) begin
            scan_mode    <= s.mode;
            slash_held   <= s.sl;
            star_seen    <= s.st;
            line_content <= s.lc;
            ws_count     <= s.cnt;
            ws_lost      <= s.lost;
            fl_cnt       <= s.fcnt;
            fl_idx       <= '0;
            fl_lost      <= s.flost;
            tail_byte    <= s.tb;
            tail_idx     <= 2'd0;
            tail_eot     <= s_axis_tlast;
            tail_bare    <= (s.n == 2'd0);
            tail_n       <= (s.n == 2'd0) ? 2'd1 : s.n;
            pend         <= s.push && s.flush;
            pend_byte    <= s.pbyte;
            pend_addr    <= s.paddr;
            if (s.flush) begin
              state <= S_RD;
            end else if (s.n != 2'd0 || s_axis_tlast) begin
              state <= S_TAIL;
            end
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (out_free) begin
            o_byte  <= ram_rdata;
            o_last  <= 1'b0;
            o_user  <= {fl_lost, 1'b0, 1'b1};
            fl_idx  <= fl_idx + CW'(1);
            state   <= (fl_idx + CW'(1) == fl_cnt) ? S_TAIL : S_RD;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            o_byte   <= tail_bare ? 8'd0 : tail_byte[tail_idx];
            o_last   <= tail_last;
            o_user   <= {1'b0, tail_last && tail_eot, !tail_bare};
            tail_idx <= tail_idx + 2'd1;
            if (tail_last) begin
              pend  <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The end of a document returns the scanner to its reset state.
  a_doc_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_hs && s_axis_tlast |=> scan_mode == MODE_TEXT && !slash_held && !line_content
      && ws_count == '0 && !ws_lost)
    else $error("scanner state not cleared after end of document");

  // A release never reads past the held whitespace.
  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> fl_idx < fl_cnt && fl_cnt <= CNT_FULL)
    else $error("whitespace release reads beyond fill count");

  // Released whitespace is always followed by the content that released it.
  a_ovf_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tlast && m_axis_tuser[0])
    else $error("overflow-marked whitespace ends a run");

  // The fill count never exceeds the memory depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_hs |=> ws_count <= CNT_FULL)
    else $error("whitespace fill count overflow");
`endif

endmodule
